[sv/dc1d_pkg.sv]
// ----------------------------------------------------------------------------
// dc1d_pkg
// shared types and codes of the dilated 1d convolution engine
// ----------------------------------------------------------------------------
package dc1d_pkg;

	// command opcodes
	localparam logic [1:0] OP_LOAD_ACT  = 2'd0;
	localparam logic [1:0] OP_LOAD_WGT  = 2'd1;
	localparam logic [1:0] OP_LOAD_BIAS = 2'd2;
	localparam logic [1:0] OP_COMPUTE   = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_IN_CH   = 3'd0;
	localparam logic [2:0] REG_OUT_CH  = 3'd1;
	localparam logic [2:0] REG_TAPS    = 3'd2;
	localparam logic [2:0] REG_DIL     = 3'd3;
	localparam logic [2:0] REG_PAD     = 3'd4;
	localparam logic [2:0] REG_IN_LEN  = 3'd5;
	localparam logic [2:0] REG_OUT_LEN = 3'd6;

	localparam int CFG_W  = 7;
	localparam int ACC_W  = 48;
	localparam int FRAC_W = 12;
	localparam int RES_CAP = 16;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [11:0]        address;
		logic signed [15:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] result_value;
		logic [3:0]         channel_index;
		logic [3:0]         time_index;
		logic               saturated;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [6:0] in_channels;
		logic [4:0] out_channels;
		logic [2:0] kernel_taps;
		logic [3:0] dilation_step;
		logic [4:0] pad_amount;
		logic [4:0] input_length;
		logic [4:0] output_length;
	} cfg_t;

	// one slot issued into the arithmetic pipe
	typedef struct packed {
		logic       init;
		logic       mac;
		logic       fin;
		logic       last;
		logic [3:0] t;
		logic [3:0] ch;
	} tag_t;

endpackage

[sv/dilated_conv1d_engine.sv]
// ----------------------------------------------------------------------------
// dilated_conv1d_engine
// stride-1 dilated 1d convolution, fixed point, one shared mac under a sequencer
// loads are written straight into the stores and busy stays low for them
// a compute transaction holds busy while the single mac walks every channel and
//   tap of each output step, and until the arithmetic pipe has drained
// async reset restores register defaults; store contents are left as they are
// ----------------------------------------------------------------------------
module dilated_conv1d_engine #(
	parameter int MAX_IN_CH  = 64,
	parameter int MAX_OUT_CH = 16,
	parameter int MAX_LEN    = 16,
	parameter int MAX_TAPS   = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command transaction
	input  logic                  start,
	output logic                  busy,
	input  dc1d_pkg::cmd_t        cmd,
	// register write transaction
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [dc1d_pkg::CFG_W-1:0] cfg_data,
	// results, one per strobe, cannot be stalled
	output dc1d_pkg::res_t        result,
	output logic                  strobe
);

	localparam int ACT_DEPTH  = MAX_IN_CH * MAX_LEN;
	localparam int WGT_DEPTH  = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
	localparam int BIAS_DEPTH = MAX_OUT_CH;
	localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int BIAS_AW    = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;

	dc1d_pkg::cfg_t    cfg_q;
	dc1d_pkg::tag_t    tag;
	logic              take;
	logic              go;
	logic              act_we, wgt_we, bias_we;
	logic              act_re, wgt_re, bias_re;
	logic [ACT_AW-1:0] act_raddr;
	logic [WGT_AW-1:0] wgt_raddr;
	logic [BIAS_AW-1:0] bias_raddr;
	logic [15:0]       act_rdata, wgt_rdata, bias_rdata;
	logic              pipe_busy;

	// command transaction accepted this edge
	assign take = start && !busy;
	assign go   = take && (cmd.opcode == dc1d_pkg::OP_COMPUTE);

	// loads go straight into the stores, indexes past the end are dropped
	assign act_we  = take && (cmd.opcode == dc1d_pkg::OP_LOAD_ACT)
		&& (32'(cmd.address) < 32'(ACT_DEPTH));
	assign wgt_we  = take && (cmd.opcode == dc1d_pkg::OP_LOAD_WGT)
		&& (32'(cmd.address) < 32'(WGT_DEPTH));
	assign bias_we = take && (cmd.opcode == dc1d_pkg::OP_LOAD_BIAS)
		&& (32'(cmd.address) < 32'(BIAS_DEPTH));

	// registers only change between computes
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels   <= 7'd1;
			cfg_q.out_channels  <= 5'd1;
			cfg_q.kernel_taps   <= 3'd1;
			cfg_q.dilation_step <= 4'd1;
			cfg_q.pad_amount    <= 5'd0;
			cfg_q.input_length  <= 5'd16;
			cfg_q.output_length <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dc1d_pkg::REG_IN_CH:   cfg_q.in_channels   <= cfg_data;
				dc1d_pkg::REG_OUT_CH:  cfg_q.out_channels  <= cfg_data[4:0];
				dc1d_pkg::REG_TAPS:    cfg_q.kernel_taps   <= cfg_data[2:0];
				dc1d_pkg::REG_DIL:     cfg_q.dilation_step <= cfg_data[3:0];
				dc1d_pkg::REG_PAD:     cfg_q.pad_amount    <= cfg_data[4:0];
				dc1d_pkg::REG_IN_LEN:  cfg_q.input_length  <= cfg_data[4:0];
				dc1d_pkg::REG_OUT_LEN: cfg_q.output_length <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// activations, channel-major
	dc1d_ram #(.DEPTH(ACT_DEPTH), .AW(ACT_AW)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (ACT_AW'(cmd.address)),
		.wdata (cmd.load_value),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	// weights, out channel then in channel then tap
	dc1d_ram #(.DEPTH(WGT_DEPTH), .AW(WGT_AW)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (WGT_AW'(cmd.address)),
		.wdata (cmd.load_value),
		.re    (wgt_re),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	// one bias per output channel
	dc1d_ram #(.DEPTH(BIAS_DEPTH), .AW(BIAS_AW)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (BIAS_AW'(cmd.address)),
		.wdata (cmd.load_value),
		.re    (bias_re),
		.raddr (bias_raddr),
		.rdata (bias_rdata)
	);

	// sequencer: per output step one bias slot, one slot per channel and tap,
	// then a finish slot; out-of-range positions become empty slots
	dc1d_seq #(
		.MAX_IN_CH  (MAX_IN_CH),
		.MAX_OUT_CH (MAX_OUT_CH),
		.MAX_LEN    (MAX_LEN),
		.MAX_TAPS   (MAX_TAPS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.go_oc     (cmd.address),
		.cfg       (cfg_q),
		.pipe_busy (pipe_busy),
		.busy      (busy),
		.tag       (tag),
		.act_re    (act_re),
		.act_addr  (act_raddr),
		.wgt_re    (wgt_re),
		.wgt_addr  (wgt_raddr),
		.bias_re   (bias_re),
		.bias_addr (bias_raddr)
	);

	// shared mac: read, multiply, accumulate, then round and clip on finish
	dc1d_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag),
		.wgt       (wgt_rdata),
		.act       (act_rdata),
		.bias      (bias_rdata),
		.pipe_busy (pipe_busy),
		.result    (result),
		.strobe    (strobe)
	);

endmodule

[sv/dc1d_ram.sv]
// ----------------------------------------------------------------------------
// dc1d_ram
// single write port, single registered read port storage
// ----------------------------------------------------------------------------
module dc1d_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/dc1d_mac.sv]
// ----------------------------------------------------------------------------
// dc1d_mac
// shared multiply-accumulate unit with rounding, saturation and result register
// ----------------------------------------------------------------------------
module dc1d_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  dc1d_pkg::tag_t     tag_in,
	input  logic signed [15:0] wgt,
	input  logic signed [15:0] act,
	input  logic signed [15:0] bias,
	output logic               pipe_busy,
	output dc1d_pkg::res_t     result,
	output logic               strobe
);

	localparam int ACC_W = dc1d_pkg::ACC_W;
	localparam int Q_W   = ACC_W - dc1d_pkg::FRAC_W;

	dc1d_pkg::tag_t          tag_s1, tag_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]      mul;
	logic signed [ACC_W-1:0] bias_ext;
	logic signed [Q_W-1:0]   q;
	logic signed [15:0]      q_sat;
	logic                    q_hi, q_lo;
	dc1d_pkg::res_t          res_q;
	logic                    strobe_q;

	assign mul      = wgt * act;
	assign bias_ext = {{(ACC_W - 16 - dc1d_pkg::FRAC_W){bias[15]}}, bias,
		{dc1d_pkg::FRAC_W{1'b0}}};

	// floor shift, then clip
	assign q     = Q_W'(acc_q >>> dc1d_pkg::FRAC_W);
	assign q_hi  = q > Q_W'(32767);
	assign q_lo  = q < -Q_W'(32768);
	assign q_sat = q_hi ? 16'sh7FFF : (q_lo ? -16'sh8000 : q[15:0]);

	assign pipe_busy = tag_s1.init | tag_s1.mac | tag_s1.fin
		| tag_s2.init | tag_s2.mac | tag_s2.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1   <= '0;
			tag_s2   <= '0;
			strobe_q <= 1'b0;
		end else begin
			tag_s1   <= tag_in;
			tag_s2   <= tag_s1;
			strobe_q <= tag_s2.fin;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= tag_s1.init ? bias_ext : ACC_W'(mul);
		if (tag_s2.init) begin
			acc_q <= prod_s2;
		end else if (tag_s2.mac) begin
			acc_q <= acc_q + prod_s2;
		end
		if (tag_s2.fin) begin
			res_q.result_value  <= q_sat;
			res_q.channel_index <= tag_s2.ch;
			res_q.time_index    <= tag_s2.t;
			res_q.saturated     <= q_hi | q_lo;
			res_q.last          <= tag_s2.last;
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule

[sv/dc1d_seq.sv]
// ----------------------------------------------------------------------------
// dc1d_seq
// sequencer: walks output steps, input channels and taps, issues reads and slots
// ----------------------------------------------------------------------------
module dc1d_seq #(
	parameter int MAX_IN_CH  = 64,
	parameter int MAX_OUT_CH = 16,
	parameter int MAX_LEN    = 16,
	parameter int MAX_TAPS   = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [11:0]    go_oc,
	input  dc1d_pkg::cfg_t cfg,
	input  logic           pipe_busy,
	output logic           busy,
	output dc1d_pkg::tag_t tag,
	output logic           act_re,
	output logic [((MAX_IN_CH*MAX_LEN > 1) ? $clog2(MAX_IN_CH*MAX_LEN) : 1)-1:0] act_addr,
	output logic           wgt_re,
	output logic [((MAX_OUT_CH*MAX_IN_CH*MAX_TAPS > 1) ?
		$clog2(MAX_OUT_CH*MAX_IN_CH*MAX_TAPS) : 1)-1:0] wgt_addr,
	output logic           bias_re,
	output logic [((MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1)-1:0] bias_addr
);

	localparam int ACT_DEPTH = MAX_IN_CH * MAX_LEN;
	localparam int WGT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
	localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
	localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int OCW       = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int ICNW      = $clog2(MAX_IN_CH + 1);
	localparam int OCNW      = $clog2(MAX_OUT_CH + 1);
	localparam int KNW       = $clog2(MAX_TAPS + 1);
	localparam int LIW       = $clog2(MAX_LEN + 1);
	localparam int LO_MAX    = (MAX_LEN < dc1d_pkg::RES_CAP) ? MAX_LEN : dc1d_pkg::RES_CAP;
	localparam int POS_W     = $clog2(MAX_LEN + MAX_TAPS * 16 + 48) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL1  = 3'd1;
	localparam logic [2:0] S_MUL2  = 3'd2;
	localparam logic [2:0] S_INIT  = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;

	logic [2:0]              state_q;
	logic [OCW-1:0]          oc_q;
	logic [4:0]              t_q;
	logic [ICNW-1:0]         ic_q;
	logic [KNW-1:0]          k_q;
	logic signed [POS_W-1:0] pos_q;
	logic [WGT_AW-1:0]       wptr_q, wbase_q;
	logic [ACT_AW:0]         abase_q;

	logic [ICNW-1:0]         ic_n;
	logic [OCNW-1:0]         oc_n;
	logic [KNW-1:0]          k_n;
	logic [LIW-1:0]          li;
	logic [4:0]              lo;
	logic signed [POS_W-1:0] pos_start, dil;
	logic                    pos_ok, k_last, ic_last, t_last, oc_ok;

	// register values beyond the supported size are clamped
	assign ic_n = (32'(cfg.in_channels) > 32'(MAX_IN_CH)) ? ICNW'(MAX_IN_CH)
		: ICNW'(cfg.in_channels);
	assign oc_n = (32'(cfg.out_channels) > 32'(MAX_OUT_CH)) ? OCNW'(MAX_OUT_CH)
		: OCNW'(cfg.out_channels);
	assign k_n  = (32'(cfg.kernel_taps) > 32'(MAX_TAPS)) ? KNW'(MAX_TAPS)
		: KNW'(cfg.kernel_taps);
	assign li   = (32'(cfg.input_length) > 32'(MAX_LEN)) ? LIW'(MAX_LEN)
		: LIW'(cfg.input_length);
	assign lo   = (32'(cfg.output_length) > 32'(LO_MAX)) ? 5'(LO_MAX) : cfg.output_length;

	assign pos_start = $signed(POS_W'(t_q)) - $signed(POS_W'(cfg.pad_amount));
	assign dil       = $signed(POS_W'(cfg.dilation_step));
	assign pos_ok    = !pos_q[POS_W-1] && (pos_q < $signed(POS_W'(li)));
	assign k_last    = (k_q + KNW'(1)) == k_n;
	assign ic_last   = (ic_q + ICNW'(1)) == ic_n;
	assign t_last    = (t_q + 5'd1) == lo;
	assign oc_ok     = (32'(go_oc) < 32'(oc_n)) && (lo != 5'd0);

	assign busy = state_q != S_IDLE;

	always_comb begin
		tag       = '0;
		tag.t     = 4'(t_q);
		tag.ch    = 4'(oc_q);
		act_re    = 1'b0;
		wgt_re    = 1'b0;
		bias_re   = 1'b0;
		act_addr  = ACT_AW'(abase_q) + ACT_AW'($unsigned(pos_q));
		wgt_addr  = wptr_q;
		bias_addr = oc_q;
		case (state_q)
			S_INIT: begin
				tag.init = 1'b1;
				bias_re  = 1'b1;
			end
			S_RUN: begin
				tag.mac = pos_ok;
				act_re  = pos_ok;
				wgt_re  = pos_ok;
			end
			S_FIN: begin
				tag.fin  = 1'b1;
				tag.last = t_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go && oc_ok) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_INIT;
				S_INIT: begin
					state_q <= (ic_n != '0 && k_n != '0) ? S_RUN : S_FIN;
				end
				S_RUN: begin
					if (k_last && ic_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= t_last ? S_DRAIN : S_INIT;
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				oc_q <= OCW'(go_oc);
				t_q  <= 5'd0;
			end
			S_MUL1: wbase_q <= WGT_AW'(oc_q) * WGT_AW'(ic_n);
			S_MUL2: wbase_q <= wbase_q * WGT_AW'(k_n);
			S_INIT: begin
				ic_q    <= '0;
				k_q     <= '0;
				pos_q   <= pos_start;
				wptr_q  <= wbase_q;
				abase_q <= '0;
			end
			S_RUN: begin
				wptr_q <= wptr_q + WGT_AW'(1);
				if (k_last) begin
					k_q     <= '0;
					ic_q    <= ic_q + ICNW'(1);
					abase_q <= abase_q + (ACT_AW + 1)'(li);
					pos_q   <= pos_start;
				end else begin
					k_q   <= k_q + KNW'(1);
					pos_q <= pos_q + dil;
				end
			end
			S_FIN: begin
				t_q <= t_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dilated 1d convolution engine: a directed table
// of loads and single-sample computes, a sweep of extreme, oversized and zero
// register settings, then random phases of loads and computes; every output
// sample is checked against the answer of its table row or an in-bench
// fixed-point predictor of the engine
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// sizes the engine is built with (its parameter defaults)
	localparam int MAX_IN_CH  = 64;
	localparam int MAX_OUT_CH = 16;
	localparam int MAX_LEN    = 16;
	localparam int MAX_TAPS   = 4;
	localparam int ACT_DEPTH  = MAX_IN_CH * MAX_LEN;
	localparam int WGT_DEPTH  = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
	localparam int BIAS_DEPTH = MAX_OUT_CH;

	// register slot past the last real one, writes to it must be dropped
	localparam logic [2:0] REG_NONE = 3'd7;

	// no transaction for this long means the engine has hung
	localparam int STALL_LIMIT = 20000;
	// quiet cycles after the last sample, longer than one output step
	localparam int TAIL_CYCLES = 300;
	localparam int RANDOM_PHASES = 3;
	localparam int ITEMS_PER_PHASE = 10;

	// one row of the directed table; typed rows carry their own answer
	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] addr;
		logic [15:0] val;
		logic        typed;
		logic [15:0] want;
		logic        want_sat;
	} step_t;

	// settings for the table: one channel, one tap, one step in and out,
	// so each typed compute is a single sample of bias + weight*activation
	localparam step_t DIR_STEPS [26] = '{
		// 1.0 * 1.0 + 0.5
		'{dc1d_pkg::OP_LOAD_ACT,  12'd0,    16'h0100, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_WGT,  12'd0,    16'h1000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd0,    16'h0080, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd0,    16'h0000, 1'b1, 16'h0180, 1'b0},
		// largest positive everywhere, clips high
		'{dc1d_pkg::OP_LOAD_ACT,  12'd0,    16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_WGT,  12'd0,    16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd0,    16'h7fff, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd0,    16'hffff, 1'b1, 16'h7fff, 1'b1},
		// most negative weight and bias, clips low
		'{dc1d_pkg::OP_LOAD_WGT,  12'd0,    16'h8000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd0,    16'h8000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd0,    16'h0000, 1'b1, 16'h8000, 1'b1},
		// tiny negative product rounds down to -1 lsb
		'{dc1d_pkg::OP_LOAD_ACT,  12'd0,    16'hffff, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_WGT,  12'd0,    16'h0001, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd0,    16'h0000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd0,    16'h0000, 1'b1, 16'hffff, 1'b0},
		// top channel, zero weight leaves the bias alone
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd15,   16'h1234, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_WGT,  12'd15,   16'h0000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd15,   16'h0000, 1'b1, 16'h1234, 1'b0},
		// last valid entries, then loads past the end that must be dropped
		'{dc1d_pkg::OP_LOAD_ACT,  12'd1023, 16'h5a5a, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_WGT,  12'd4095, 16'ha5a5, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_ACT,  12'd1024, 16'h7777, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd16,   16'h7777, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_LOAD_BIAS, 12'd4095, 16'h7777, 1'b0, 16'h0000, 1'b0},
		// stores untouched by the dropped loads; channels past the count give nothing
		'{dc1d_pkg::OP_COMPUTE,   12'd0,    16'h0000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd16,   16'h0000, 1'b0, 16'h0000, 1'b0},
		'{dc1d_pkg::OP_COMPUTE,   12'd4095, 16'hffff, 1'b0, 16'h0000, 1'b0}
	};

	// dut ports
	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	dc1d_pkg::cmd_t cmd;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [dc1d_pkg::CFG_W-1:0] cfg_data;
	dc1d_pkg::res_t result;
	logic strobe;

	// predictor state: stores, which entries hold data, register copy
	logic signed [15:0] act_mem  [ACT_DEPTH];
	logic signed [15:0] wgt_mem  [WGT_DEPTH];
	logic signed [15:0] bias_mem [BIAS_DEPTH];
	bit act_set  [ACT_DEPTH];
	bit wgt_set  [WGT_DEPTH];
	bit bias_set [BIAS_DEPTH];
	dc1d_pkg::cfg_t shadow;
	// effective sizes after clamping
	int ic_n, oc_n, k_n, li, lo, dil, pad;

	// samples still owed by the engine, oldest first
	dc1d_pkg::res_t samples_due [$];
	dc1d_pkg::res_t due_now;

	int gap_pct;
	int idle_cycles = 0;
	int errors;
	int n_loads, n_computes, n_cfg_writes, n_settings, n_samples, n_clipped;

	dilated_conv1d_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.strobe    (strobe)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void refresh_limits();
		ic_n = (shadow.in_channels > MAX_IN_CH) ? MAX_IN_CH : int'(shadow.in_channels);
		oc_n = (shadow.out_channels > MAX_OUT_CH) ? MAX_OUT_CH : int'(shadow.out_channels);
		k_n  = (shadow.kernel_taps > MAX_TAPS) ? MAX_TAPS : int'(shadow.kernel_taps);
		li   = (shadow.input_length > MAX_LEN) ? MAX_LEN : int'(shadow.input_length);
		lo   = (shadow.output_length > MAX_LEN) ? MAX_LEN : int'(shadow.output_length);
		if (lo > dc1d_pkg::RES_CAP)
			lo = dc1d_pkg::RES_CAP;
		dil = int'(shadow.dilation_step);
		pad = int'(shadow.pad_amount);
	endfunction

	// queue every sample a compute of channel oc will produce
	function automatic void predict_channel(input logic [11:0] oc);
		longint acc, q;
		int pos, widx, aidx;
		dc1d_pkg::res_t s;
		if (oc >= oc_n)
			return;
		for (int t = 0; t < lo; t++) begin
			// bias is q8.8, lift it to the q12.20 scale of the products
			acc = longint'(bias_mem[oc[3:0]]) * (longint'(1) << dc1d_pkg::FRAC_W);
			for (int ic = 0; ic < ic_n; ic++) begin
				for (int k = 0; k < k_n; k++) begin
					pos = t + k * dil - pad;
					// outside the input window counts as zero padding
					if (pos < 0 || pos >= li)
						continue;
					widx = (int'(oc) * ic_n + ic) * k_n + k;
					aidx = ic * li + pos;
					acc += longint'(wgt_mem[widx]) * longint'(act_mem[aidx]);
				end
			end
			// arithmetic shift floors toward minus infinity
			q = acc >>> dc1d_pkg::FRAC_W;
			s.saturated = 1'b0;
			if (q > 32767) begin
				q = 32767;
				s.saturated = 1'b1;
			end else if (q < -32768) begin
				q = -32768;
				s.saturated = 1'b1;
			end
			s.result_value  = q[15:0];
			s.channel_index = oc[3:0];
			s.time_index    = t[3:0];
			s.last          = (t == lo - 1);
			samples_due.push_back(s);
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	// mostly small values so sums stay in range, some full-range and extremes
	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'(int'($urandom_range(0, 1023)) - 512);
		if (r < 85)
			return 16'($urandom);
		return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
	endfunction

	// register value: usually within the legal range, now and then anything
	function automatic int spread(input int lo_v, input int hi_v, input int wide);
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, wide);
		return $urandom_range(lo_v, hi_v);
	endfunction

	function automatic logic [1:0] load_op(input int n);
		case (n)
			0:       return dc1d_pkg::OP_LOAD_ACT;
			1:       return dc1d_pkg::OP_LOAD_WGT;
			default: return dc1d_pkg::OP_LOAD_BIAS;
		endcase
	endfunction

	// one command transaction; start is held until the engine takes it
	task automatic issue(input logic [1:0] op, input logic [11:0] addr,
			input logic [15:0] val, input bit typed = 1'b0,
			input logic [15:0] want = '0, input bit want_sat = 1'b0);
		dc1d_pkg::cmd_t c;
		dc1d_pkg::res_t s;
		c.opcode     = op;
		c.address    = addr;
		c.load_value = val;
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		// taken at this edge: update the stores or predict the samples
		case (op)
			dc1d_pkg::OP_LOAD_ACT: begin
				n_loads++;
				if (addr < ACT_DEPTH) begin
					act_mem[addr] = val;
					act_set[addr] = 1'b1;
				end
			end
			dc1d_pkg::OP_LOAD_WGT: begin
				n_loads++;
				if (addr < WGT_DEPTH) begin
					wgt_mem[addr] = val;
					wgt_set[addr] = 1'b1;
				end
			end
			dc1d_pkg::OP_LOAD_BIAS: begin
				n_loads++;
				if (addr < BIAS_DEPTH) begin
					bias_mem[addr] = val;
					bias_set[addr] = 1'b1;
				end
			end
			default: begin
				n_computes++;
				if (typed) begin
					s.result_value  = want;
					s.channel_index = addr[3:0];
					s.time_index    = '0;
					s.saturated     = want_sat;
					s.last          = 1'b1;
					samples_due.push_back(s);
				end else begin
					predict_channel(addr);
				end
			end
		endcase
		@(negedge clk);
		// random idle burst on the command side
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// write every entry a compute of oc will read that was never written,
	// so the engine is never asked for an undefined store entry
	task automatic preload_channel(input logic [11:0] oc);
		int pos, widx, aidx;
		if (!bias_set[oc[3:0]])
			issue(dc1d_pkg::OP_LOAD_BIAS, oc, pick_value());
		for (int t = 0; t < lo; t++) begin
			for (int ic = 0; ic < ic_n; ic++) begin
				for (int k = 0; k < k_n; k++) begin
					pos = t + k * dil - pad;
					if (pos < 0 || pos >= li)
						continue;
					widx = (int'(oc) * ic_n + ic) * k_n + k;
					aidx = ic * li + pos;
					if (!wgt_set[widx])
						issue(dc1d_pkg::OP_LOAD_WGT, 12'(widx), pick_value());
					if (!act_set[aidx])
						issue(dc1d_pkg::OP_LOAD_ACT, 12'(aidx), pick_value());
				end
			end
		end
	endtask

	task automatic compute_channel(input logic [11:0] oc);
		if (oc < oc_n)
			preload_channel(oc);
		issue(dc1d_pkg::OP_COMPUTE, oc, pick_value());
	endtask

	// wait until every owed sample is in and the engine is idle
	task automatic settle();
		start <= 1'b0;
		while (samples_due.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write transaction
	task automatic write_reg(input logic [2:0] idx, input int val);
		logic [dc1d_pkg::CFG_W-1:0] d;
		d = val[dc1d_pkg::CFG_W-1:0];
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dc1d_pkg::REG_IN_CH:   shadow.in_channels   = d[6:0];
			dc1d_pkg::REG_OUT_CH:  shadow.out_channels  = d[4:0];
			dc1d_pkg::REG_TAPS:    shadow.kernel_taps   = d[2:0];
			dc1d_pkg::REG_DIL:     shadow.dilation_step = d[3:0];
			dc1d_pkg::REG_PAD:     shadow.pad_amount    = d[4:0];
			dc1d_pkg::REG_IN_LEN:  shadow.input_length  = d[4:0];
			dc1d_pkg::REG_OUT_LEN: shadow.output_length = d[4:0];
			default: ;
		endcase
		refresh_limits();
		n_cfg_writes++;
		@(negedge clk);
		if ($urandom_range(0, 99) < gap_pct) begin
			cfg_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// full register set, plus a write to the unused slot that must be dropped
	task automatic configure(input int ich, input int och, input int taps,
			input int dil_v, input int pad_v, input int ilen, input int olen);
		write_reg(dc1d_pkg::REG_IN_CH, ich);
		write_reg(dc1d_pkg::REG_OUT_CH, och);
		write_reg(dc1d_pkg::REG_TAPS, taps);
		write_reg(dc1d_pkg::REG_DIL, dil_v);
		write_reg(dc1d_pkg::REG_PAD, pad_v);
		write_reg(dc1d_pkg::REG_IN_LEN, ilen);
		write_reg(dc1d_pkg::REG_OUT_LEN, olen);
		write_reg(REG_NONE, $urandom_range(0, 127));
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// random item: mostly loads into the live layout and computes of live
	// channels, the rest loads anywhere and computes of dead channels
	task automatic random_item();
		int r, kind, span;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			kind = $urandom_range(0, 2);
			op = load_op(kind);
			span = (kind == 0) ? ic_n * li : (kind == 1) ? oc_n * ic_n * k_n : oc_n;
			if (span > 0)
				issue(op, 12'($urandom_range(0, span - 1)), pick_value());
			else
				issue(op, 12'($urandom_range(0, 4095)), pick_value());
		end else if (r < 55) begin
			issue(load_op($urandom_range(0, 2)), 12'($urandom_range(0, 4095)), pick_value());
		end else if (r < 85 && oc_n > 0) begin
			compute_channel(12'($urandom_range(0, oc_n - 1)));
		end else if ($urandom_range(0, 1) == 0) begin
			compute_channel(12'($urandom_range(0, 4095)));
		end else begin
			compute_channel(12'($urandom_range(oc_n, 31)));
		end
	endtask

	// ------------------------------------------------------------------
	// sample checker: every strobe must match the oldest owed sample
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			n_samples++;
			if (result.saturated)
				n_clipped++;
			if (samples_due.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected sample value %h ch %0d t %0d sat %0b last %0b",
					$time, result.result_value, result.channel_index,
					result.time_index, result.saturated, result.last);
			end else begin
				due_now = samples_due.pop_front();
				if (result !== due_now) begin
					errors++;
					$display("%0t ns: expected value %h ch %0d t %0d sat %0b last %0b",
						$time, due_now.result_value, due_now.channel_index,
						due_now.time_index, due_now.saturated, due_now.last);
					$display("%0t ns: actual   value %h ch %0d t %0d sat %0b last %0b",
						$time, result.result_value, result.channel_index,
						result.time_index, result.saturated, result.last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: any accepted transaction or sample restarts the count
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles, %0d samples still owed",
					$time, idle_cycles, samples_due.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		// every input known from time zero, reset asserted before the first edge
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		gap_pct     = 20;
		errors      = 0;
		shadow      = dc1d_pkg::cfg_t'{7'd1, 5'd1, 3'd1, 4'd1, 5'd0, 5'd16, 5'd16};
		refresh_limits();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: one channel, one tap, sixteen steps
		compute_channel(12'd0);
		compute_channel(12'd1);

		// directed table with single-sample settings
		settle();
		configure(1, 16, 1, 1, 0, 1, 1);
		foreach (DIR_STEPS[i])
			issue(DIR_STEPS[i].op, DIR_STEPS[i].addr, DIR_STEPS[i].val,
				DIR_STEPS[i].typed, DIR_STEPS[i].want, DIR_STEPS[i].want_sat);

		// largest taps and lengths, dilation 8 and padding 16, one full compute
		settle();
		configure(2, 16, 4, 8, 16, 16, 16);
		compute_channel(12'($urandom_range(0, 15)));
		compute_channel(12'd16);

		// all but the input channel count at all-ones; the engine clamps the counts and lengths
		settle();
		configure(2, 31, 7, 15, 31, 31, 31);
		compute_channel(12'($urandom_range(0, 15)));
		compute_channel(12'd31);

		// oversized channel count with the window shifted before the start of the input
		settle();
		configure(127, 1, 1, 1, 1, 1, 1);
		compute_channel(12'd0);
		compute_channel(12'd1);

		// no input channels: bias only; zero dilation stacks the taps
		settle();
		configure(0, 4, 2, 0, 0, 4, 4);
		compute_channel(12'd0);
		compute_channel(12'd3);

		// no taps: bias only
		settle();
		configure(2, 2, 0, 3, 1, 5, 3);
		compute_channel(12'd1);

		// empty input window: every activation reads as zero
		settle();
		configure(2, 2, 2, 0, 0, 0, 5);
		compute_channel(12'd0);

		// no output channels, then no output steps: computes give nothing
		settle();
		configure(1, 0, 1, 1, 0, 16, 16);
		compute_channel(12'd0);
		settle();
		configure(1, 2, 1, 1, 0, 16, 0);
		compute_channel(12'd0);
		compute_channel(12'd1);

		// random phases; the final one runs without idle gaps
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			gap_pct = (ph == RANDOM_PHASES - 1) ? 0 : 25 * $urandom_range(0, 2);
			configure(spread(1, 3, 3), spread(1, 16, 31), spread(1, 4, 7),
				spread(1, 8, 15), spread(0, 16, 31), spread(1, 16, 31),
				spread(1, 16, 31));
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				random_item();
		end

		// drain, then watch for stray samples
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d loads and %0d computes over %0d register settings (%0d writes)",
			n_loads, n_computes, n_settings, n_cfg_writes);
		$display("checked %0d output samples, %0d of them clipped, %0d mismatches",
			n_samples, n_clipped, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
sv/dc1d_pkg.sv
sv/dc1d_ram.sv
sv/dc1d_mac.sv
sv/dc1d_seq.sv
sv/dilated_conv1d_engine.sv
test/tb_top.sv
